// ===== rtl/adb_device_response_transmitter_unit_defines.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ADB_DEVICE_RESPONSE_TRANSMITTER_UNIT_DEFINES_SVH
`define ADB_DEVICE_RESPONSE_TRANSMITTER_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define ADB_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("adb transmitter check failed");

// Consequent checked in the cycle after the antecedent.
`define ADB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("adb transmitter check failed");

`endif

// ===== rtl/adb_drt_pkg.sv =====
`timescale 1ns / 1ps

package adb_drt_pkg;

    localparam int MAX_RESPONSE_BYTES = 8;

    localparam int CFG_W    = 16;
    localparam int TIME_W   = 20;
    localparam int IDX_W    = $clog2(MAX_RESPONSE_BYTES);
    localparam int LEN_W    = $clog2(MAX_RESPONSE_BYTES + 1);
    localparam int TOT_W    = LEN_W + 3;
    localparam int POS_W    = $clog2(MAX_RESPONSE_BYTES * 8 + 2) + 1;
    localparam int SUM_W    = TIME_W + 2;
    localparam int DCNT_W   = $clog2(TIME_W);
    localparam int CIDX_W   = 3;
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 8;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_LOAD = 2'd1,
        KIND_SRQ  = 2'd2
    } kind_t;

    typedef enum logic [CIDX_W-1:0] {
        REG_BIT_CELL     = 3'd0,
        REG_STOP_START   = 3'd1,
        REG_SRQ_TIME     = 3'd2,
        REG_ZERO_LOW     = 3'd3,
        REG_ONE_LOW      = 3'd4
    } cfg_idx_t;

    localparam logic [CFG_W-1:0] RST_BIT_CELL   = 16'd1600;
    localparam logic [CFG_W-1:0] RST_STOP_START = 16'd2400;
    localparam logic [CFG_W-1:0] RST_SRQ_TIME   = 16'd3840;
    localparam logic [CFG_W-1:0] RST_ZERO_LOW   = 16'd1056;
    localparam logic [CFG_W-1:0] RST_ONE_LOW    = 16'd528;

endpackage

// ===== rtl/adb_device_response_transmitter_unit.sv =====
`timescale 1ns / 1ps

// ADB device response transmitter. Each input word is a time tick, a response
// byte load or a service request, and each gives exactly one output word with
// the line level the device drives, the response-pending flag and the
// service-request flag. Load, service-request and unused words, and ticks that
// only run the service-request pulse or find nothing to send, pass from the
// capture step to the output register; a tick that is still waiting out the
// stop-to-start gap passes the gap check first. A tick that moves the bit
// timing finds the cell count with one restoring divider that retires one
// quotient bit per cycle, after the gap step where one is due and before the
// position step and, unless the response ends, the line-level step. One
// word is in the block at a time: s_tready stays low until its result has
// been loaded into the output register and rises in the following cycle,
// and a result still waiting there holds the block in its last step. Times
// are in 1/16 microsecond units.
module adb_device_response_transmitter_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // [15:0] elapsed, [16] bus_level, [24:17] data_byte, zero above
    input  logic [adb_drt_pkg::S_DATA_W-1:0]    s_tdata,
    // [1:0] kind
    input  logic [adb_drt_pkg::S_USER_W-1:0]    s_tuser,
    input  logic                                s_tlast,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] line_out, [1] busy_res, [2] srq_active, zero above
    output logic [adb_drt_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_wr_en,
    input  logic [adb_drt_pkg::CIDX_W-1:0]      cfg_index,
    input  logic [adb_drt_pkg::CFG_W-1:0]       cfg_wdata
);
    import adb_drt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_GAP,
        ST_DIV,
        ST_POST,
        ST_BIT,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic [CFG_W-1:0] bit_cell_reg, stop_start_reg, srq_time_reg, zero_low_reg, one_low_reg;

    // Captured input word.
    kind_t            kind_reg;
    logic [15:0]      elapsed_reg;
    logic             bus_reg;
    logic [7:0]       data_reg;
    logic             final_reg;

    logic [7:0]       store_reg [MAX_RESPONSE_BYTES];
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] load_cnt_reg;
    logic [POS_W-1:0] pos_reg;
    logic [TIME_W-1:0] time_reg;
    logic             srq_reg;
    logic             line_reg;

    // Divider working registers: quot_reg shifts the dividend out and the
    // quotient in; rem_reg holds the partial remainder.
    logic [TIME_W-1:0] quot_reg;
    logic [CFG_W-1:0]  rem_reg;
    logic [DCNT_W-1:0] dcnt_reg;

    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_valid_reg;

    logic [TIME_W:0]   t_sum;
    logic [TIME_W-1:0] t_sat;
    logic [CFG_W-1:0]  cell_len;
    logic [CFG_W:0]    rem_sh;
    logic              rem_ge;
    logic [CFG_W:0]    rem_diff;
    logic [TOT_W-1:0]  total_bits;
    logic [SUM_W-1:0]  pos_sum;
    logic [SUM_W-1:0]  end_pos;
    logic              at_end;
    logic              cur_bit;
    logic [LEN_W-1:0]  load_cnt_inc;
    logic              load_room;
    logic              out_free;
    logic [POS_W-1:0]  POS_WAIT;

    assign POS_WAIT   = POS_W'(-2);
    assign t_sum      = {1'b0, time_reg} + (TIME_W + 1)'(elapsed_reg);
    assign t_sat      = t_sum[TIME_W] ? TIME_MAX : t_sum[TIME_W-1:0];
    assign cell_len   = (bit_cell_reg == '0) ? CFG_W'(1) : bit_cell_reg;
    assign rem_sh     = {rem_reg, quot_reg[TIME_W-1]};
    assign rem_diff   = rem_sh - {1'b0, cell_len};
    assign rem_ge     = (rem_sh >= {1'b0, cell_len});
    assign total_bits = {len_reg, 3'b000};
    assign pos_sum    = {{(SUM_W-POS_W){pos_reg[POS_W-1]}}, pos_reg} + SUM_W'(quot_reg);
    assign end_pos    = SUM_W'(total_bits) + SUM_W'(1);
    assign at_end     = $signed(pos_sum) >= $signed(end_pos);
    assign load_room  = (load_cnt_reg < LEN_W'(MAX_RESPONSE_BYTES));
    assign load_cnt_inc = load_room ? load_cnt_reg + LEN_W'(1) : load_cnt_reg;
    assign out_free   = !m_valid_reg || m_tready;

    // Start bit before the data, stop bit after it.
    always_comb begin
        if (pos_reg[POS_W-1]) begin
            cur_bit = 1'b1;
        end else if (pos_reg < POS_W'(total_bits)) begin
            cur_bit = store_reg[pos_reg[IDX_W+2:3]][3'd7 - pos_reg[2:0]];
        end else begin
            cur_bit = 1'b0;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tdata  = m_data_reg;
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_cell_reg   <= RST_BIT_CELL;
            stop_start_reg <= RST_STOP_START;
            srq_time_reg   <= RST_SRQ_TIME;
            zero_low_reg   <= RST_ZERO_LOW;
            one_low_reg    <= RST_ONE_LOW;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BIT_CELL:   bit_cell_reg   <= cfg_wdata;
                REG_STOP_START: stop_start_reg <= cfg_wdata;
                REG_SRQ_TIME:   srq_time_reg   <= cfg_wdata;
                REG_ZERO_LOW:   zero_low_reg   <= cfg_wdata;
                REG_ONE_LOW:    one_low_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            len_reg      <= '0;
            load_cnt_reg <= '0;
            pos_reg      <= POS_WAIT;
            time_reg     <= '0;
            srq_reg      <= 1'b0;
            line_reg     <= 1'b1;
            m_valid_reg  <= 1'b0;
        end else begin
            // A word taken in the cycle that the next result is loaded is
            // replaced rather than cleared.
            if (m_valid_reg && m_tready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg    <= kind_t'(s_tuser[1:0]);
                        elapsed_reg <= s_tdata[15:0];
                        bus_reg     <= s_tdata[16];
                        data_reg    <= s_tdata[24:17];
                        final_reg   <= s_tlast;
                        state_reg   <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    unique case (kind_reg)
                        KIND_TICK: begin
                            if (srq_reg) begin
                                time_reg  <= t_sat;
                                state_reg <= ST_DONE;
                                if (t_sat < TIME_W'(srq_time_reg)) begin
                                    line_reg <= 1'b0;
                                end else begin
                                    line_reg <= 1'b1;
                                    srq_reg  <= 1'b0;
                                end
                            end else if (len_reg != '0 &&
                                         !(!bus_reg && pos_reg == POS_WAIT)) begin
                                time_reg <= t_sat;
                                state_reg <= (pos_reg == POS_WAIT) ? ST_GAP : ST_DIV;
                                rem_reg   <= '0;
                                dcnt_reg  <= DCNT_W'(TIME_W - 1);
                                quot_reg  <= t_sat;
                            end else begin
                                state_reg <= ST_DONE;
                            end
                        end
                        KIND_LOAD: begin
                            state_reg <= ST_DONE;
                            if (load_room) begin
                                store_reg[load_cnt_reg[IDX_W-1:0]] <= data_reg;
                            end
                            if (final_reg) begin
                                len_reg      <= load_cnt_inc;
                                load_cnt_reg <= '0;
                                time_reg     <= '0;
                                pos_reg      <= POS_WAIT;
                            end else begin
                                load_cnt_reg <= load_cnt_inc;
                            end
                        end
                        KIND_SRQ: begin
                            srq_reg   <= 1'b1;
                            time_reg  <= '0;
                            state_reg <= ST_DONE;
                        end
                        default: state_reg <= ST_DONE;
                    endcase
                end
                ST_GAP: begin
                    if (time_reg < TIME_W'(stop_start_reg)) begin
                        state_reg <= ST_DONE;
                    end else begin
                        time_reg  <= time_reg - TIME_W'(stop_start_reg);
                        quot_reg  <= time_reg - TIME_W'(stop_start_reg);
                        pos_reg   <= POS_W'(-1);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg  <= rem_ge ? rem_diff[CFG_W-1:0] : rem_sh[CFG_W-1:0];
                    quot_reg <= {quot_reg[TIME_W-2:0], rem_ge};
                    dcnt_reg <= dcnt_reg - DCNT_W'(1);
                    if (dcnt_reg == '0) begin
                        state_reg <= ST_POST;
                    end
                end
                ST_POST: begin
                    time_reg <= TIME_W'(rem_reg);
                    if (at_end) begin
                        pos_reg   <= POS_W'(end_pos);
                        line_reg  <= 1'b1;
                        len_reg   <= '0;
                        state_reg <= ST_DONE;
                    end else begin
                        pos_reg   <= pos_sum[POS_W-1:0];
                        state_reg <= ST_BIT;
                    end
                end
                ST_BIT: begin
                    line_reg  <= time_reg > TIME_W'(cur_bit ? one_low_reg : zero_low_reg);
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_data_reg  <= {{(M_DATA_W-3){1'b0}}, srq_reg, (len_reg != '0),
                                        line_reg};
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/adb_drt_checker.sv =====
`timescale 1ns / 1ps
`include "adb_device_response_transmitter_unit_defines.svh"

module adb_drt_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [adb_drt_pkg::M_DATA_W-1:0]    m_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready
);
    import adb_drt_pkg::*;

    // A word waiting at the output keeps its value until it is taken.
    `ADB_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // Each word is processed before the next is taken, so the input closes straight after acceptance.
    `ADB_ASSERT_NEXT(a_one_word, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // An idle block stays ready while nothing is offered.
    `ADB_ASSERT_NEXT(a_idle_ready, aclk, aresetn, s_tready && !s_tvalid, s_tready)
    // The padding bits of a result are always zero.
    `ADB_ASSERT_SAME(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[M_DATA_W-1:3] == '0)

endmodule

bind adb_device_response_transmitter_unit adb_drt_checker u_adb_drt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
